### design/wrsd_pkg.sv
// Shared constants, register indexes and types for the windowed RMS sound detector.
// Used by the interfaces and by every module of the block; depends on nothing else.
package wrsd_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int MAX_WINDOW     = 1024;
	localparam int MIN_WINDOW     = 2;
	localparam int LEN_BITS       = 11;
	localparam int LEVEL_BITS     = 12;
	localparam int RMSQ_BITS      = 24;
	localparam int SUM_BITS       = 22;
	localparam int SQSUM_BITS     = 34;
	localparam int SQ_BITS        = 2 * SAMPLE_BITS;
	localparam int MUL_BITS       = 24;
	localparam int PROD_BITS      = 2 * MUL_BITS;
	localparam int QSPLIT         = 17;
	localparam int NQ_PART_BITS   = LEN_BITS + QSPLIT;
	localparam int SPREAD_BITS    = 45;
	localparam int SUMSQ_BITS     = 2 * SUM_BITS;
	localparam int NN_BITS        = 2 * LEN_BITS - 1;
	localparam int MEAN_LIM_BITS  = SUM_BITS + 1;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MEAN_LEVEL    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RMS_LIMIT_SQ  = 2'd2;

	localparam logic [LEN_BITS-1:0]   WINDOW_LENGTH_RST = 11'd200;
	localparam logic [LEVEL_BITS-1:0] MEAN_LEVEL_RST    = 12'd2055;
	localparam logic [RMSQ_BITS-1:0]  RMS_LIMIT_SQ_RST  = 24'd100;

	// One request to the shared multiplier; the product register loads only when en is set.
	typedef struct packed {
		logic                en;
		logic [MUL_BITS-1:0] a;
		logic [MUL_BITS-1:0] b;
	} mul_req_t;

	// Window result handed from the sequencer to the output register.
	typedef struct packed {
		logic                done;
		logic                detected;
		logic [SUM_BITS-1:0] total;
	} win_result_t;

endpackage

### design/wrsd_if.sv
// Handshake channels of the detector: the sample input and the window result output.
// Depends on wrsd_pkg for the field widths.
interface wrsd_sample_if
	import wrsd_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface wrsd_result_if
	import wrsd_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic                detected;
	logic [SUM_BITS-1:0] window_total;

	modport source(output valid, output detected, output window_total, input ready);
	modport sink(input valid, input detected, input window_total, output ready);
endinterface

### design/wrsd_mul.sv
// Shared 24 x 24 unsigned multiplier with a registered product.
// Depends on wrsd_pkg for the request type and widths.
module wrsd_mul
	import wrsd_pkg::*;
(
	input  logic                 clk,
	input  mul_req_t             req,
	output logic [PROD_BITS-1:0] prod
);

	logic [PROD_BITS-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_BITS'(req.a) * PROD_BITS'(req.b);
		end
	end

	assign prod = prod_q;

endmodule

### design/wrsd_seq.sv
// Sequencer and accumulators: squares each sample, keeps the window sums and, at the
// window end, runs the exact variance and mean tests through the shared multiplier.
// Depends on wrsd_pkg.
module wrsd_seq
	import wrsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output logic                   in_ready,
	input  logic [LEN_BITS-1:0]    eff_len,
	input  logic [LEVEL_BITS-1:0]  mean_level,
	input  logic [RMSQ_BITS-1:0]   rms_limit_sq,
	input  logic                   out_free,
	output win_result_t            result,
	output mul_req_t               mul_req,
	input  logic [PROD_BITS-1:0]   prod
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SQR  = 10'b00_0000_0010,
		S_ACC  = 10'b00_0000_0100,
		S_SS   = 10'b00_0000_1000,
		S_NQL  = 10'b00_0001_0000,
		S_NQH  = 10'b00_0010_0000,
		S_NN   = 10'b00_0100_0000,
		S_RL   = 10'b00_1000_0000,
		S_LV   = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} seq_state_t;

	seq_state_t              state_q;
	logic [SAMPLE_BITS-1:0]  sample_q;
	logic [LEN_BITS-1:0]     count_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic [SQSUM_BITS-1:0]   sqsum_q;
	logic [SUMSQ_BITS-1:0]   sumsq_q;
	logic [SPREAD_BITS-1:0]  spread_q;
	logic                    loud_q;
	logic [LEN_BITS-1:0]     count_inc;
	logic                    bright;

	assign count_inc = count_q + 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign bright    = {1'b0, sum_q} > prod[MEAN_LIM_BITS-1:0];

	assign result.done     = (state_q == S_OUT) && out_free;
	assign result.detected = loud_q && bright;
	assign result.total    = sum_q;

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_SQR: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(sample_q);
				mul_req.b  = MUL_BITS'(sample_q);
			end
			S_SS: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(sum_q);
				mul_req.b  = MUL_BITS'(sum_q);
			end
			S_NQL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(eff_len);
				mul_req.b  = MUL_BITS'(sqsum_q[QSPLIT-1:0]);
			end
			S_NQH: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(eff_len);
				mul_req.b  = MUL_BITS'(sqsum_q[SQSUM_BITS-1:QSPLIT]);
			end
			S_NN: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(eff_len);
				mul_req.b  = MUL_BITS'(eff_len);
			end
			S_RL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(rms_limit_sq);
				mul_req.b  = MUL_BITS'(prod[NN_BITS-1:0]);
			end
			S_LV: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_BITS'(mean_level);
				mul_req.b  = MUL_BITS'(eff_len);
			end
			S_IDLE, S_ACC, S_OUT: begin
				mul_req.en = 1'b0;
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q   <= sum_q + SUM_BITS'(sample_q);
					sqsum_q <= sqsum_q + SQSUM_BITS'(prod[SQ_BITS-1:0]);
					count_q <= count_inc;
					// The window also closes when the length was lowered below the count.
					state_q <= (count_inc >= eff_len) ? S_SS : S_IDLE;
				end
				S_SS:  state_q <= S_NQL;
				S_NQL: state_q <= S_NQH;
				S_NQH: state_q <= S_NN;
				S_NN:  state_q <= S_RL;
				S_RL:  state_q <= S_LV;
				S_LV:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						count_q <= '0;
						sum_q   <= '0;
						sqsum_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					sample_q <= in_sample;
				end
			end
			S_NQL: sumsq_q <= prod[SUMSQ_BITS-1:0];
			S_NQH: spread_q <= SPREAD_BITS'(prod[NQ_PART_BITS-1:0]);
			S_NN: begin
				spread_q <= spread_q + {prod[NQ_PART_BITS-1:0], {QSPLIT{1'b0}}};
			end
			S_RL: begin
				// N*Q - S*S, floored at zero.
				if (spread_q > SPREAD_BITS'(sumsq_q)) begin
					spread_q <= spread_q - SPREAD_BITS'(sumsq_q);
				end else begin
					spread_q <= '0;
				end
			end
			S_LV: loud_q <= spread_q > prod[SPREAD_BITS-1:0];
			default: begin
			end
		endcase
	end

endmodule

### design/windowed_rms_sound_detector_top.sv
// Windowed RMS sound detector: each sample is latched, squared on the
// shared 24 x 24 multiplier and accumulated, and the sample that closes a window
// passes S_SS to S_OUT while the same multiplier forms S*S, N*Q in two halves,
// N*N, the RMS limit times N*N and the mean level times N; the exact tests are
// N*Q - S*S > rms_limit_squared*N*N and S > mean_level*N. A finished result sits
// in an output register, so the next sample is taken while it waits; the window
// end stalls only if the previous result has not been taken yet.
// Depends on wrsd_pkg, wrsd_if, wrsd_mul and wrsd_seq.
module windowed_rms_sound_detector_top
	import wrsd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	wrsd_sample_if.sink               samples,
	wrsd_result_if.source             results
);

	logic [LEN_BITS-1:0]   window_length_q;
	logic [LEVEL_BITS-1:0] mean_level_q;
	logic [RMSQ_BITS-1:0]  rms_limit_sq_q;
	logic [LEN_BITS-1:0]   eff_len;
	logic                  out_valid_q;
	logic                  detected_q;
	logic [SUM_BITS-1:0]   total_q;
	logic                  out_free;
	win_result_t           result;
	mul_req_t              mul_req;
	logic [PROD_BITS-1:0]  prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			mean_level_q    <= MEAN_LEVEL_RST;
			rms_limit_sq_q  <= RMS_LIMIT_SQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[LEN_BITS-1:0];
				REG_MEAN_LEVEL:    mean_level_q    <= cfg_data[LEVEL_BITS-1:0];
				REG_RMS_LIMIT_SQ:  rms_limit_sq_q  <= cfg_data[RMSQ_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (window_length_q < LEN_BITS'(MIN_WINDOW)) begin
			eff_len = LEN_BITS'(MIN_WINDOW);
		end else if (window_length_q > LEN_BITS'(MAX_WINDOW)) begin
			eff_len = LEN_BITS'(MAX_WINDOW);
		end else begin
			eff_len = window_length_q;
		end
	end

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.done) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.done) begin
			detected_q <= result.detected;
			total_q    <= result.total;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.detected     = detected_q;
	assign results.window_total = total_q;

	wrsd_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	wrsd_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_sample    (samples.sample),
		.in_ready     (samples.ready),
		.eff_len      (eff_len),
		.mean_level   (mean_level_q),
		.rms_limit_sq (rms_limit_sq_q),
		.out_free     (out_free),
		.result       (result),
		.mul_req      (mul_req),
		.prod         (prod)
	);

endmodule

### tb/sv/tb_windowed_rms_sound_detector_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_rms_sound_detector_top: a directed table and random
// windows with their own window predictor. Depends on wrsd_pkg, wrsd_if and the detector RTL.
module tb_windowed_rms_sound_detector_top;
	import wrsd_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 133;
	localparam int BIG_FIRST     = 500;

	typedef struct packed {
		logic                detected;
		logic [SUM_BITS-1:0] total;
	} window_verdict_t;

	typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t                kind;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
		logic                      typed;
		window_verdict_t           want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 27;

	// Rows with a typed result close a two-sample window whose outcome is plain to see.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{STEP_WRITE,  REG_UNUSED,        24'd2,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd4095,     1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd4095,     1'b0, '0},
		'{STEP_WRITE,  REG_WINDOW_LENGTH, 24'd2,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd4095,     1'b0, '0},
		'{STEP_WRITE,  REG_MEAN_LEVEL,    24'd0,        1'b0, '0},
		'{STEP_WRITE,  REG_RMS_LIMIT_SQ,  24'd0,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd0,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd4095,     1'b1, '{1'b1, 22'd4095}},
		'{STEP_SAMPLE, '0,                24'd0,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd0,        1'b1, '{1'b0, 22'd0}},
		'{STEP_WRITE,  REG_MEAN_LEVEL,    24'd4095,     1'b0, '0},
		'{STEP_WRITE,  REG_RMS_LIMIT_SQ,  24'hFFFFFF,   1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd4095,     1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd0,        1'b1, '{1'b0, 22'd4095}},
		'{STEP_WRITE,  REG_WINDOW_LENGTH, 24'd0,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd100,      1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd200,      1'b0, '0},
		'{STEP_WRITE,  REG_WINDOW_LENGTH, 24'd1,        1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd2048,     1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd1,        1'b0, '0},
		'{STEP_WRITE,  REG_MEAN_LEVEL,    24'd1000,     1'b0, '0},
		'{STEP_WRITE,  REG_RMS_LIMIT_SQ,  24'd1,        1'b0, '0},
		'{STEP_WRITE,  REG_WINDOW_LENGTH, 24'hFFF803,   1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd1000,     1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd1000,     1'b0, '0},
		'{STEP_SAMPLE, '0,                24'd1003,     1'b0, '0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	wrsd_sample_if sample_ch ();
	wrsd_result_if result_ch ();

	windowed_rms_sound_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_ch),
		.results   (result_ch)
	);

	// Shadow registers and accumulators of the window predictor.
	logic [LEN_BITS-1:0]   len_cfg;
	logic [LEVEL_BITS-1:0] level_cfg;
	logic [RMSQ_BITS-1:0]  rms_sq_cfg;
	int                    win_count;
	longint unsigned       win_sum;
	longint unsigned       win_sqsum;

	window_verdict_t pending_windows [$];

	int send_idle_pct;
	int recv_idle_pct;
	int errors = 0;
	int samples_sent;
	int windows_checked = 0;
	int windows_flagged = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int window_size();
		if (len_cfg < MIN_WINDOW) begin
			return MIN_WINDOW;
		end
		if (len_cfg > MAX_WINDOW) begin
			return MAX_WINDOW;
		end
		return int'(len_cfg);
	endfunction

	// Adds one sample to the open window; closes it once the count reaches the length.
	task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s, output logic closed,
			output window_verdict_t verdict);
		longint unsigned n;
		longint unsigned sq;
		longint unsigned spread;
		longint unsigned limit;
		logic            loud;
		logic            bright;
		n = longint'(window_size());
		win_sum   += longint'(s);
		win_sqsum += longint'(s) * longint'(s);
		win_count += 1;
		closed  = 1'b0;
		verdict = '0;
		if (longint'(win_count) >= n) begin
			sq     = win_sum * win_sum;
			spread = n * win_sqsum;
			spread = (spread > sq) ? spread - sq : 64'd0;
			limit  = longint'(rms_sq_cfg) * n * n;
			loud   = spread > limit;
			bright = win_sum > longint'(level_cfg) * n;
			closed           = 1'b1;
			verdict.detected = loud && bright;
			verdict.total    = win_sum[SUM_BITS-1:0];
			win_count = 0;
			win_sum   = 0;
			win_sqsum = 0;
		end
	endtask

	// Parks the input channel and waits until the block has drained every window result.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_windows.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_WINDOW_LENGTH: len_cfg    = data[LEN_BITS-1:0];
			REG_MEAN_LEVEL:    level_cfg  = data[LEVEL_BITS-1:0];
			REG_RMS_LIMIT_SQ:  rms_sq_cfg = data[RMSQ_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic typed,
			input window_verdict_t want);
		logic            closed;
		window_verdict_t verdict;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
		samples_sent++;
		accumulate_sample(s, closed, verdict);
		if (closed) begin
			pending_windows.push_back(typed ? want : verdict);
		end
	endtask

	task automatic run_random_phase(input int items);
		int                     sent;
		int                     count;
		int                     roll;
		int                     len;
		int                     style;
		int                     base;
		int                     spread;
		int                     level;
		int                     value;
		logic [RMSQ_BITS-1:0]   rms;
		sent = 0;
		while (sent < items) begin
			settle();
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				len = $urandom_range(2, 12);
			end else if (roll < 8) begin
				len = $urandom_range(0, 1);
			end else begin
				len = $urandom_range(13, 40);
			end
			// Upper data bits are noise the register has to drop.
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_WINDOW_LENGTH, CFG_DATA_BITS'(($urandom & 24'hFFF800) | len));
			end
			if ($urandom_range(0, 1) != 0) begin
				level = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4095)
					: $urandom_range(1500, 2600);
				write_reg(REG_MEAN_LEVEL, CFG_DATA_BITS'(($urandom & 24'hFFF000) | level));
			end
			if ($urandom_range(0, 1) != 0) begin
				roll = $urandom_range(0, 4);
				if (roll < 3) begin
					rms = RMSQ_BITS'($urandom_range(0, 2000000));
				end else if (roll < 4) begin
					rms = RMSQ_BITS'($urandom_range(0, 200));
				end else begin
					rms = RMSQ_BITS'($urandom);
				end
				write_reg(REG_RMS_LIMIT_SQ, rms);
			end
			count  = window_size() * $urandom_range(1, 3) + $urandom_range(0, window_size() - 1);
			style  = $urandom_range(0, 2);
			base   = $urandom_range(0, 4095);
			spread = $urandom_range(0, 600);
			repeat (count) begin
				case (style)
					0: value = $urandom_range(0, 4095);
					1: value = base + $urandom_range(0, 2 * spread) - spread;
					default: value = ($urandom_range(0, 1) != 0) ? 4095 : 0;
				endcase
				if (value < 0) begin
					value = 0;
				end
				if (value > 4095) begin
					value = 4095;
				end
				send_sample(SAMPLE_BITS'(value), 1'b0, '0);
			end
			sent += count;
		end
	endtask

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		window_verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_windows.size() == 0) begin
				$display("%0t: window result with none expected: detected %0b, total %0d",
					$time, result_ch.detected, result_ch.window_total);
				errors++;
			end else begin
				want = pending_windows.pop_front();
				windows_checked++;
				if (want.detected) begin
					windows_flagged++;
				end
				if (result_ch.detected !== want.detected) begin
					$display("%0t: detected mismatch: expected %0b, actual %0b",
						$time, want.detected, result_ch.detected);
					errors++;
				end
				if (result_ch.window_total !== want.total) begin
					$display("%0t: window_total mismatch: expected %0d, actual %0d",
						$time, want.total, result_ch.window_total);
					errors++;
				end
			end
		end
	end

	// A run that stops moving anything for too long has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
					|| cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		len_cfg          = WINDOW_LENGTH_RST;
		level_cfg        = MEAN_LEVEL_RST;
		rms_sq_cfg       = RMS_LIMIT_SQ_RST;
		win_count        = 0;
		win_sum          = 0;
		win_sqsum        = 0;
		samples_sent     = 0;
		send_idle_pct    = 26;
		recv_idle_pct    = 62;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == STEP_WRITE) begin
				settle();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_sample(directed_rows[i].data[SAMPLE_BITS-1:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		run_random_phase(PHASE_ITEMS);
		send_idle_pct = 62;
		recv_idle_pct = 26;
		run_random_phase(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(PHASE_ITEMS);

		// One full-length window of full-scale samples; the length register moves from
		// its largest legal value to its largest raw value while the window is open.
		settle();
		write_reg(REG_WINDOW_LENGTH, CFG_DATA_BITS'(MAX_WINDOW));
		write_reg(REG_MEAN_LEVEL, 24'd4094);
		write_reg(REG_RMS_LIMIT_SQ, 24'd0);
		repeat (BIG_FIRST) send_sample(12'hFFF, 1'b0, '0);
		settle();
		write_reg(REG_WINDOW_LENGTH, 24'h0007FF);
		repeat (MAX_WINDOW - BIG_FIRST) send_sample(12'hFFF, 1'b0, '0);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d samples over directed, random and full-length windows;", samples_sent);
		$display("checked %0d window results, %0d of them flagged as detected.",
			windows_checked, windows_flagged);
		if (errors == 0 && pending_windows.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
